>>> hw/rtl/pfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Shared types, character codes and the symbol decoder of the postfix
// expression evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int unsigned VALUE_W   = 48;
  localparam int unsigned SYMBOL_W  = 8;
  localparam int unsigned MUL_STEPS = 4;

  localparam logic [SYMBOL_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [SYMBOL_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [SYMBOL_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYMBOL_W-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [SYMBOL_W-1:0] CHAR_SLASH = 8'h2F;

  localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_ZERO
  } op_e;

  typedef struct packed {
    logic load;
    logic pop;
    logic cap_right;
    logic cap_left;
    logic exec;
    logic mul_step;
    logic div_step;
    logic fin;
    logic push;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_e  in_op;
    op_e  op;
    logic last;
    logic step_done;
    logic div_zero;
    logic out_busy;
  } sts_t;

  function automatic op_e decode_symbol(input logic [SYMBOL_W-1:0] sym);
    op_e op;
    op = OP_ZERO;
    if (sym inside {[CHAR_ZERO:CHAR_NINE]}) begin
      op = OP_DIGIT;
    end else begin
      case (sym)
        CHAR_PLUS:  op = OP_ADD;
        CHAR_MINUS: op = OP_SUB;
        CHAR_STAR:  op = OP_MUL;
        CHAR_SLASH: op = OP_DIV;
        default:    op = OP_ZERO;
      endcase
    end
    return op;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pfe_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Postfix evaluator input channel
// Carries one expression character per word.
// ----------------------------------------------------------------------------
interface pfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_expression;

  modport source (output valid, output symbol, output end_of_expression, input ready);
  modport sink   (input valid, input symbol, input end_of_expression, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/pfe_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Postfix evaluator output channel
// Carries the final value and the sticky error flags per word.
// ----------------------------------------------------------------------------
interface pfe_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] value;
  logic        underflow_seen;
  logic        overflow_seen;
  logic        divide_by_zero_seen;

  modport source (output valid, output value, output underflow_seen,
                  output overflow_seen, output divide_by_zero_seen, input ready);
  modport sink   (input valid, input value, input underflow_seen,
                  input overflow_seen, input divide_by_zero_seen, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/pfe_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfe_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   wr_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]                       wr_data_i,
  input  wire logic                                   rd_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output      logic [WIDTH-1:0]                       rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/pfe_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Postfix evaluator controller
// Sequences pops, arithmetic, pushes and the final result for each word.
// ----------------------------------------------------------------------------
module pfe_ctrl import pfe_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_ready_o,
  input  wire sts_t sts_i,
  output      cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PUSH   = 4'd1;
  localparam logic [3:0] S_POP_R  = 4'd2;
  localparam logic [3:0] S_POP_L  = 4'd3;
  localparam logic [3:0] S_LOAD_L = 4'd4;
  localparam logic [3:0] S_EXEC   = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;
  localparam logic [3:0] S_FPOP   = 4'd9;
  localparam logic [3:0] S_FCAP   = 4'd10;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (sts_i.in_op == OP_DIGIT) ? S_PUSH : S_POP_R;
        end
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = sts_i.last ? S_FPOP : S_IDLE;
      end
      S_POP_R: begin
        cmd_o.pop = 1'b1;
        state_d   = S_POP_L;
      end
      S_POP_L: begin
        cmd_o.cap_right = 1'b1;
        cmd_o.pop       = 1'b1;
        state_d         = S_LOAD_L;
      end
      S_LOAD_L: begin
        cmd_o.cap_left = 1'b1;
        state_d        = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        case (sts_i.op)
          OP_MUL:  state_d = S_MUL;
          OP_DIV:  state_d = sts_i.div_zero ? S_PUSH : S_DIV;
          default: state_d = S_PUSH;
        endcase
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.step_done) begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.step_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_PUSH;
      end
      S_FPOP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_FCAP;
      end
      S_FCAP: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/pfe_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Postfix evaluator datapath
// Operand stack, sticky flags, shared multiply and divide unit and the
// output register.
// ----------------------------------------------------------------------------
module pfe_datapath import pfe_pkg::*; #(
  parameter int unsigned STACK_DEPTH   = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [SYMBOL_W-1:0] symbol_i,
  input  wire logic                last_i,
  input  wire cmd_t                cmd_i,
  output      sts_t                sts_o,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic [VALUE_W-1:0]  out_value_o,
  output      logic                out_udf_o,
  output      logic                out_ovf_o,
  output      logic                out_dz_o
);

  localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned NW  = VALUE_W + FRACTION_BITS;
  localparam int unsigned PW  = 2 * VALUE_W;
  localparam int unsigned HW  = VALUE_W / 2;
  localparam int unsigned SCW = $clog2(NW);
  localparam logic [CW-1:0]  DEPTH_C  = CW'(STACK_DEPTH);
  localparam logic [SCW-1:0] DIV_LAST = SCW'(NW - 1);
  localparam logic [SCW-1:0] MUL_LAST = SCW'(MUL_STEPS);

  op_e               op_q;
  logic              last_q;
  logic [CW-1:0]     count_q;
  logic              udf_q, ovf_q, dz_q;
  logic              pop_empty_q;
  logic              out_valid_q;
  logic [VALUE_W-1:0] left_q, right_q, mag_a_q, mag_b_q, res_q, rem_q, pp_q;
  logic              neg_q;
  logic [PW-1:0]     acc_q;
  logic [SCW-1:0]    cnt_q;

  logic [CW-1:0]      count_m1;
  logic [VALUE_W-1:0] rd_data, pop_val, pop_mag;
  logic               wr_en, rd_en;
  logic [VALUE_W:0]   sum_add, sum_sub;
  logic [VALUE_W-1:0] sat_add, sat_sub;
  logic [HW-1:0]      a_half, b_half;
  logic [VALUE_W-1:0] pp_next;
  logic [1:0]         prev_idx;
  logic [PW-1:0]      pp_ext, pp_shift;
  logic [VALUE_W:0]   rem_try, rem_diff;
  logic               q_bit;
  logic [PW-1:0]      mag_full, limit;
  logic [VALUE_W-1:0] fin_val;

  assign count_m1 = count_q - CW'(1);
  assign wr_en    = cmd_i.push && (count_q != DEPTH_C);
  assign rd_en    = cmd_i.pop && (count_q != '0);

  pfe_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AW-1:0]),
    .wr_data_i (res_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (count_m1[AW-1:0]),
    .rd_data_o (rd_data)
  );

  assign pop_val = pop_empty_q ? '0 : rd_data;
  assign pop_mag = pop_val[VALUE_W-1] ? (~pop_val + VALUE_W'(1)) : pop_val;

  assign sum_add = {left_q[VALUE_W-1], left_q} + {right_q[VALUE_W-1], right_q};
  assign sum_sub = {left_q[VALUE_W-1], left_q} - {right_q[VALUE_W-1], right_q};
  assign sat_add = (sum_add[VALUE_W] != sum_add[VALUE_W-1]) ?
                   (sum_add[VALUE_W] ? VAL_MIN : VAL_MAX) : sum_add[VALUE_W-1:0];
  assign sat_sub = (sum_sub[VALUE_W] != sum_sub[VALUE_W-1]) ?
                   (sum_sub[VALUE_W] ? VAL_MIN : VAL_MAX) : sum_sub[VALUE_W-1:0];

  assign a_half  = cnt_q[0] ? mag_a_q[VALUE_W-1:HW] : mag_a_q[HW-1:0];
  assign b_half  = cnt_q[1] ? mag_b_q[VALUE_W-1:HW] : mag_b_q[HW-1:0];
  assign pp_next = a_half * b_half;
  assign prev_idx = cnt_q[1:0] - 2'd1;
  assign pp_ext   = PW'(pp_q);

  always_comb begin
    case (prev_idx)
      2'b00:   pp_shift = pp_ext;
      2'b11:   pp_shift = pp_ext << VALUE_W;
      default: pp_shift = pp_ext << HW;
    endcase
  end

  assign rem_try  = {rem_q, acc_q[NW-1]};
  assign rem_diff = rem_try - {1'b0, mag_b_q};
  assign q_bit    = (rem_try >= {1'b0, mag_b_q});

  assign mag_full = (op_q == OP_DIV) ? PW'(acc_q[NW-1:0]) : (acc_q >> FRACTION_BITS);
  assign limit    = neg_q ? PW'(VAL_MIN) : PW'(VAL_MAX);
  assign fin_val  = (mag_full > limit) ? (neg_q ? VAL_MIN : VAL_MAX) :
                    (neg_q ? (~mag_full[VALUE_W-1:0] + VALUE_W'(1)) : mag_full[VALUE_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= OP_ZERO;
      last_q      <= 1'b0;
      count_q     <= '0;
      udf_q       <= 1'b0;
      ovf_q       <= 1'b0;
      dz_q        <= 1'b0;
      pop_empty_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        op_q   <= decode_symbol(symbol_i);
        last_q <= last_i;
      end
      if (cmd_i.pop) begin
        if (count_q == '0) begin
          udf_q       <= 1'b1;
          pop_empty_q <= 1'b1;
        end else begin
          count_q     <= count_m1;
          pop_empty_q <= 1'b0;
        end
      end
      if (cmd_i.push) begin
        if (count_q == DEPTH_C) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CW'(1);
        end
      end
      if (cmd_i.exec && (op_q == OP_DIV) && (mag_b_q == '0)) begin
        dz_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        count_q     <= '0;
        udf_q       <= 1'b0;
        ovf_q       <= 1'b0;
        dz_q        <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q <= VALUE_W'(symbol_i - CHAR_ZERO) << FRACTION_BITS;
    end
    if (cmd_i.cap_right) begin
      right_q <= pop_val;
      mag_b_q <= pop_mag;
    end
    if (cmd_i.cap_left) begin
      left_q  <= pop_val;
      mag_a_q <= pop_mag;
    end
    if (cmd_i.exec) begin
      neg_q <= left_q[VALUE_W-1] ^ right_q[VALUE_W-1];
      cnt_q <= '0;
      case (op_q)
        OP_ADD: res_q <= sat_add;
        OP_SUB: res_q <= sat_sub;
        OP_MUL: acc_q <= '0;
        OP_DIV: begin
          res_q <= left_q[VALUE_W-1] ? VAL_MIN : VAL_MAX;
          acc_q <= PW'(mag_a_q) << FRACTION_BITS;
          rem_q <= '0;
        end
        default: res_q <= '0;
      endcase
    end
    if (cmd_i.mul_step) begin
      if (cnt_q < MUL_LAST) begin
        pp_q <= pp_next;
      end
      if (cnt_q != '0) begin
        acc_q <= acc_q + pp_shift;
      end
      cnt_q <= cnt_q + SCW'(1);
    end
    if (cmd_i.div_step) begin
      rem_q <= q_bit ? rem_diff[VALUE_W-1:0] : rem_try[VALUE_W-1:0];
      acc_q <= {acc_q[PW-2:0], q_bit};
      cnt_q <= cnt_q + SCW'(1);
    end
    if (cmd_i.fin) begin
      res_q <= fin_val;
    end
    if (cmd_i.out_load) begin
      out_value_o <= pop_val;
      out_udf_o   <= udf_q;
      out_ovf_o   <= ovf_q;
      out_dz_o    <= dz_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.in_op     = decode_symbol(symbol_i);
  assign sts_o.op        = op_q;
  assign sts_o.last      = last_q;
  assign sts_o.step_done = (op_q == OP_DIV) ? (cnt_q == DIV_LAST) : (cnt_q == MUL_LAST);
  assign sts_o.div_zero  = (mag_b_q == '0);
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("Stack count exceeds the stack depth.");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop && count_q == '0) |=> (udf_q && pop_empty_q))
    else $error("A pop from an empty stack did not raise underflow.");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (count_q == '0 && !udf_q && !ovf_q && !dz_q && out_valid_q))
    else $error("Stack and flags did not clear when the result was loaded.");

endmodule
`default_nettype wire

>>> hw/rtl/postfix_expression_evaluator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates a postfix expression of digits and arithmetic operators on a
// saturating signed fixed-point operand stack held in RAM.
// ----------------------------------------------------------------------------
// A digit word is a single push; add, subtract and unknown characters pop, execute and push.
// A multiply forms four 24x24 partial products on one multiplier.
// A divide by a nonzero value produces one quotient bit per cycle in the
// restoring divider, for 48 + FRACTION_BITS bits. An end-marked word adds the
// final pop and waits while an unaccepted earlier result holds the output.
// Words are taken one at a time. Reset empties the stack and clears all flags.
module postfix_expression_evaluator import pfe_pkg::*; #(
  parameter int unsigned STACK_DEPTH   = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  pfe_in_if.sink    in_i,
  pfe_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  pfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfe_datapath #(
    .STACK_DEPTH   (STACK_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .symbol_i    (in_i.symbol),
    .last_i      (in_i.end_of_expression),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_value_o (out_o.value),
    .out_udf_o   (out_o.underflow_seen),
    .out_ovf_o   (out_o.overflow_seen),
    .out_dz_o    (out_o.divide_by_zero_seen)
  );

endmodule
`default_nettype wire

>>> verif/postfix_expression_evaluator_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Postfix expression evaluator testbench
// Sends postfix expressions one character word at a time through the input
// channel. The first expressions are fixed: the digit extremes, every operator,
// unknown characters and divides by zero. After them come random expressions:
// mostly well-formed ones, with runaway products that saturate, stacks pushed
// past their depth, broken expressions and plain noise mixed in. A predictor
// of the stack and its sticky flags in the testbench computes each final
// value, and every result word from the block is compared against it field by
// field. Both channels stall at random in bursts.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_test import pfe_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_SLOTS    = 32;
  localparam int unsigned FRACTION_BITS  = 16;
  localparam int unsigned RANDOM_WORDS   = 1250;
  localparam int unsigned TAIL_WORDS     = 150;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 120;
  localparam int unsigned PRINT_LIMIT    = 20;

  typedef logic [SYMBOL_W-1:0] symbol_t;
  typedef logic [VALUE_W-1:0]  value_t;

  typedef struct {
    symbol_t symbol;
    logic    last;
  } char_word_t;

  typedef struct {
    value_t value;
    logic   underflow;
    logic   overflow;
    logic   div_zero;
  } outcome_t;

  logic clk;
  logic rst_n;

  pfe_in_if  sym_ch ();
  pfe_out_if res_ch ();

  postfix_expression_evaluator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (sym_ch),
    .out_o  (res_ch)
  );

  char_word_t  symbol_queue[$];
  outcome_t    pending_values[$];
  char_word_t  next_word;
  outcome_t    seen;
  outcome_t    want;

  value_t      stack_mem[STACK_SLOTS];
  int unsigned stack_fill = 0;
  bit          under_seen = 1'b0;
  bit          over_seen = 1'b0;
  bit          zero_div_seen = 1'b0;

  bit          word_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned idle_pct = 20;
  int unsigned cycle_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned underflow_results = 0;
  int unsigned overflow_results = 0;
  int unsigned div_zero_results = 0;
  int unsigned saturated_results = 0;

  // Predictor of the operand stack.

  function automatic value_t magnitude(input value_t v);
    return v[VALUE_W-1] ? ~v + 1'b1 : v;
  endfunction

  function automatic value_t apply_sign(input bit neg, input logic [127:0] mag);
    logic [127:0] limit;
    limit = neg ? (128'd1 << (VALUE_W-1)) : (128'd1 << (VALUE_W-1)) - 1;
    if (mag > limit) return neg ? VAL_MIN : VAL_MAX;
    return neg ? ~mag[VALUE_W-1:0] + 1'b1 : mag[VALUE_W-1:0];
  endfunction

  function automatic value_t sum_sat(input value_t a, input value_t b, input bit subtract);
    logic [VALUE_W:0] s;
    if (subtract) begin
      s = {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
    end else begin
      s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
    end
    if (s[VALUE_W] != s[VALUE_W-1]) return s[VALUE_W] ? VAL_MIN : VAL_MAX;
    return s[VALUE_W-1:0];
  endfunction

  function automatic value_t product_sat(input value_t a, input value_t b);
    logic [127:0] p;
    p = ({80'd0, magnitude(a)} * {80'd0, magnitude(b)}) >> FRACTION_BITS;
    return apply_sign(a[VALUE_W-1] ^ b[VALUE_W-1], p);
  endfunction

  function automatic value_t quotient_sat(input value_t a, input value_t b);
    logic [127:0] q;
    if (b == '0) begin
      zero_div_seen = 1'b1;
      return a[VALUE_W-1] ? VAL_MIN : VAL_MAX;
    end
    q = ({80'd0, magnitude(a)} << FRACTION_BITS) / {80'd0, magnitude(b)};
    return apply_sign(a[VALUE_W-1] ^ b[VALUE_W-1], q);
  endfunction

  function automatic void stack_push(input value_t v);
    if (stack_fill >= STACK_SLOTS) begin
      over_seen = 1'b1;
    end else begin
      stack_mem[stack_fill] = v;
      stack_fill++;
    end
  endfunction

  function automatic value_t stack_pop();
    if (stack_fill == 0) begin
      under_seen = 1'b1;
      return '0;
    end
    stack_fill--;
    return stack_mem[stack_fill];
  endfunction

  task automatic evaluate_word(input symbol_t sym, input logic last);
    value_t   right;
    value_t   left;
    value_t   res;
    outcome_t fin;
    if (sym >= CHAR_ZERO && sym <= CHAR_NINE) begin
      stack_push(value_t'(sym - CHAR_ZERO) << FRACTION_BITS);
    end else begin
      right = stack_pop();
      left = stack_pop();
      case (sym)
        CHAR_PLUS:  res = sum_sat(left, right, 1'b0);
        CHAR_MINUS: res = sum_sat(left, right, 1'b1);
        CHAR_STAR:  res = product_sat(left, right);
        CHAR_SLASH: res = quotient_sat(left, right);
        default:    res = '0;
      endcase
      stack_push(res);
    end
    if (last) begin
      fin.value = stack_pop();
      fin.underflow = under_seen;
      fin.overflow = over_seen;
      fin.div_zero = zero_div_seen;
      pending_values.push_back(fin);
      stack_fill = 0;
      under_seen = 1'b0;
      over_seen = 1'b0;
      zero_div_seen = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input value_t got, input value_t exp_val);
    if (mismatches < PRINT_LIMIT) begin
      $display("Mismatch at %0t: %s got %0h, expected %0h", $realtime, what, got, exp_val);
    end
    mismatches++;
  endtask

  // Stimulus generation.

  function automatic symbol_t digit_char(input int unsigned d);
    return CHAR_ZERO + symbol_t'(d);
  endfunction

  function automatic bit is_known(input symbol_t sym);
    return (sym >= CHAR_ZERO && sym <= CHAR_NINE) || sym == CHAR_PLUS ||
           sym == CHAR_MINUS || sym == CHAR_STAR || sym == CHAR_SLASH;
  endfunction

  function automatic symbol_t pick_digit();
    if ($urandom_range(0, 4) == 0) return CHAR_ZERO;
    return digit_char($urandom_range(0, 9));
  endfunction

  function automatic symbol_t pick_operator();
    symbol_t sym;
    case ($urandom_range(0, 20))
      0: begin
        sym = symbol_t'($urandom_range(0, 255));
        while (is_known(sym)) sym = symbol_t'($urandom_range(0, 255));
      end
      1, 2, 3, 4, 5:      sym = CHAR_PLUS;
      6, 7, 8, 9, 10:     sym = CHAR_MINUS;
      11, 12, 13, 14, 15: sym = CHAR_STAR;
      default:            sym = CHAR_SLASH;
    endcase
    return sym;
  endfunction

  task automatic queue_word(input symbol_t sym, input logic last);
    char_word_t w;
    w.symbol = sym;
    w.last = last;
    symbol_queue.push_back(w);
  endtask

  task automatic queue_expression(input symbol_t seq[$]);
    for (int i = 0; i < seq.size(); i++) queue_word(seq[i], i == seq.size() - 1);
  endtask

  task automatic gen_expression(input bit broken);
    symbol_t     seq[$];
    int unsigned operands;
    int unsigned depth;
    int unsigned idx;
    operands = $urandom_range(1, 8);
    depth = 0;
    while (operands > 0 || depth > 1) begin
      if (depth >= 2 && (operands == 0 || $urandom_range(0, 1) == 1)) begin
        seq.push_back(pick_operator());
        depth--;
      end else begin
        seq.push_back(pick_digit());
        operands--;
        depth++;
      end
    end
    if (broken) begin
      idx = $urandom_range(0, seq.size() - 1);
      if ($urandom_range(0, 1) == 1 && seq.size() > 1) begin
        seq.delete(idx);
      end else begin
        seq.insert(idx, pick_operator());
      end
    end
    queue_expression(seq);
  endtask

  task automatic gen_runaway();
    symbol_t seq[$];
    if ($urandom_range(0, 1) == 1) begin
      seq.push_back(CHAR_ZERO);
      seq.push_back(digit_char(9));
      seq.push_back(CHAR_MINUS);
    end else begin
      seq.push_back(digit_char(9));
    end
    repeat ($urandom_range(6, 14)) begin
      seq.push_back(digit_char(9));
      seq.push_back(CHAR_STAR);
    end
    case ($urandom_range(0, 3))
      0: begin
        seq.push_back(digit_char(9));
        seq.push_back(CHAR_PLUS);
      end
      1: begin
        seq.push_back(digit_char(9));
        seq.push_back(CHAR_MINUS);
      end
      2: begin
        seq.push_back(digit_char(1));
        seq.push_back(digit_char(9));
        seq.push_back(CHAR_SLASH);
        seq.push_back(CHAR_SLASH);
      end
      default: begin
        seq.push_back(digit_char(1));
        seq.push_back(digit_char(9));
        seq.push_back(CHAR_SLASH);
        seq.push_back(CHAR_STAR);
      end
    endcase
    queue_expression(seq);
  endtask

  task automatic gen_deep_stack();
    symbol_t     seq[$];
    int unsigned pushes;
    pushes = $urandom_range(30, 36);
    repeat (pushes) seq.push_back(pick_digit());
    repeat ($urandom_range(0, pushes + 1)) seq.push_back(pick_operator());
    queue_expression(seq);
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 6)) begin
      queue_word(symbol_t'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic build_directed();
    symbol_t seq[$];
    queue_word(CHAR_ZERO, 1'b1);
    queue_word(CHAR_NINE, 1'b1);
    queue_word(8'hFF, 1'b1);
    queue_word(8'h00, 1'b1);
    seq = {digit_char(1), digit_char(2), CHAR_PLUS};
    queue_expression(seq);
    seq = {digit_char(3), digit_char(8), CHAR_MINUS};
    queue_expression(seq);
    seq = {digit_char(9), digit_char(4), CHAR_STAR};
    queue_expression(seq);
    seq = {digit_char(8), digit_char(3), CHAR_SLASH};
    queue_expression(seq);
    seq = {digit_char(5), CHAR_ZERO, CHAR_SLASH};
    queue_expression(seq);
    seq = {CHAR_ZERO, CHAR_ZERO, CHAR_SLASH};
    queue_expression(seq);
    seq = {CHAR_ZERO, digit_char(7), CHAR_MINUS, CHAR_ZERO, CHAR_SLASH};
    queue_expression(seq);
  endtask

  task automatic build_random();
    int unsigned goal;
    int unsigned pick;
    goal = symbol_queue.size() + RANDOM_WORDS;
    while (symbol_queue.size() < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        gen_expression(1'b0);
      end else if (pick < 75) begin
        gen_runaway();
      end else if (pick < 80) begin
        gen_deep_stack();
      end else if (pick < 90) begin
        gen_noise();
      end else begin
        gen_expression(1'b1);
      end
    end
    gen_expression(1'b0);
  endtask

  function automatic bit in_tail();
    return symbol_queue.size() < TAIL_WORDS;
  endfunction

  // Clock, reset and the idle pattern.

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    sym_ch.valid = 1'b0;
    sym_ch.symbol = '0;
    sym_ch.end_of_expression = 1'b0;
    res_ch.ready = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    if (rst_n && (!sym_ch.valid || word_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        sym_ch.valid <= 1'b0;
      end else if (symbol_queue.size() != 0) begin
        next_word = symbol_queue.pop_front();
        sym_ch.symbol <= next_word.symbol;
        sym_ch.end_of_expression <= next_word.last;
        sym_ch.valid <= 1'b1;
        if (!in_tail() && $urandom_range(0, 99) < idle_pct) send_gap = $urandom_range(1, 6);
      end else begin
        sym_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      if (!in_tail() && $urandom_range(0, 99) < idle_pct) stall_left = $urandom_range(1, 6);
    end
  end

  always @(posedge clk) begin
    word_taken <= rst_n && sym_ch.valid && sym_ch.ready;
    if (rst_n) begin
      cycle_count++;
      if (cycle_count % 400 == 0) begin
        case ($urandom_range(0, 3))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          2:       idle_pct = 30;
          default: idle_pct = 60;
        endcase
      end
      if (sym_ch.valid && sym_ch.ready) begin
        words_sent++;
        evaluate_word(sym_ch.symbol, sym_ch.end_of_expression);
      end
      if (res_ch.valid && res_ch.ready) begin
        seen.value = res_ch.value;
        seen.underflow = res_ch.underflow_seen;
        seen.overflow = res_ch.overflow_seen;
        seen.div_zero = res_ch.divide_by_zero_seen;
        if (pending_values.size() == 0) begin
          report_mismatch("unexpected result value", seen.value, '0);
        end else begin
          want = pending_values.pop_front();
          results_checked++;
          if (want.underflow) underflow_results++;
          if (want.overflow) overflow_results++;
          if (want.div_zero) div_zero_results++;
          if (want.value == VAL_MAX || want.value == VAL_MIN) saturated_results++;
          if (seen.value !== want.value) begin
            report_mismatch("value", seen.value, want.value);
          end
          if (seen.underflow !== want.underflow) begin
            report_mismatch("underflow_seen", value_t'(seen.underflow), value_t'(want.underflow));
          end
          if (seen.overflow !== want.overflow) begin
            report_mismatch("overflow_seen", value_t'(seen.overflow), value_t'(want.overflow));
          end
          if (seen.div_zero !== want.div_zero) begin
            report_mismatch("divide_by_zero_seen", value_t'(seen.div_zero),
                            value_t'(want.div_zero));
          end
        end
      end
      if ((sym_ch.valid && sym_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_values.size());
        $display("postfix_expression_evaluator_test failed");
        $finish;
      end
    end
  end

  initial begin
    build_directed();
    build_random();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (symbol_queue.size() != 0 || sym_ch.valid) @(posedge clk);
    while (pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d character words; checked %0d expression results.",
             words_sent, results_checked);
    $display("Results with underflow %0d, overflow %0d, divide by zero %0d, saturated %0d.",
             underflow_results, overflow_results, div_zero_results, saturated_results);
    if (mismatches == 0) begin
      $display("postfix_expression_evaluator_test passed");
    end else begin
      $display("postfix_expression_evaluator_test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
